// File: design/sssd_pkg.sv
// Shared types, constants and microcode table of the seven-segment scan driver.
package sssd_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned NUM_W      = 16;
	localparam int unsigned BITCNT_W   = 4;
	localparam int unsigned RADIX_W    = 5;
	localparam int unsigned REM_W      = 4;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned FRAME_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_EN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_POS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_ON  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_ON    = 3'd5;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [BITCNT_W-1:0] DIV_LAST_BIT   = 4'd15;
	localparam logic [BITCNT_W-1:0] FRAME_LAST_BIT = 4'd15;
	localparam logic [BYTE_W-1:0]   POINT_MASK     = 8'h80;

	typedef logic [2:0] upc_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_STORE,
		OP_NOP,
		OP_EMIT,
		OP_SCAN_ADV
	} uop_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_CNT_NZ,
		CND_DIG_MORE,
		CND_TICK
	} ucond_t;

	typedef struct packed {
		uop_t   op;
		ucond_t cnd;
		upc_t   target;
	} uword_t;

	localparam upc_t PC_WAIT     = 3'd0;
	localparam upc_t PC_DIV_INIT = 3'd1;
	localparam upc_t PC_DIV_STEP = 3'd2;
	localparam upc_t PC_STORE    = 3'd3;
	localparam upc_t PC_NOP      = 3'd4;
	localparam upc_t PC_EMIT     = 3'd5;
	localparam upc_t PC_SCAN_ADV = 3'd6;

	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		case (pc)
			PC_WAIT:     w = '{op: OP_WAIT,     cnd: CND_TICK,     target: PC_EMIT};
			PC_DIV_INIT: w = '{op: OP_DIV_INIT, cnd: CND_NEXT,     target: PC_WAIT};
			PC_DIV_STEP: w = '{op: OP_DIV_STEP, cnd: CND_CNT_NZ,   target: PC_DIV_STEP};
			PC_STORE:    w = '{op: OP_STORE,    cnd: CND_DIG_MORE, target: PC_DIV_INIT};
			PC_NOP:      w = '{op: OP_NOP,      cnd: CND_ALWAYS,   target: PC_WAIT};
			PC_EMIT:     w = '{op: OP_EMIT,     cnd: CND_CNT_NZ,   target: PC_EMIT};
			PC_SCAN_ADV: w = '{op: OP_SCAN_ADV, cnd: CND_ALWAYS,   target: PC_WAIT};
			default:     w = '{op: OP_NOP,      cnd: CND_ALWAYS,   target: PC_WAIT};
		endcase
		return w;
	endfunction

	// Hex font: bit 0 is segment a, bit 6 is segment g.
	function automatic logic [BYTE_W-1:0] hex_font(input logic [REM_W-1:0] d);
		logic [BYTE_W-1:0] m;
		unique case (d)
			4'h0: m = 8'h3F;
			4'h1: m = 8'h06;
			4'h2: m = 8'h5B;
			4'h3: m = 8'h4F;
			4'h4: m = 8'h66;
			4'h5: m = 8'h6D;
			4'h6: m = 8'h7D;
			4'h7: m = 8'h07;
			4'h8: m = 8'h7F;
			4'h9: m = 8'h6F;
			4'hA: m = 8'h77;
			4'hB: m = 8'h7C;
			4'hC: m = 8'h39;
			4'hD: m = 8'h5E;
			4'hE: m = 8'h79;
			4'hF: m = 8'h71;
		endcase
		return m;
	endfunction

endpackage

// File: design/seven_segment_scan_driver.sv
// Seven-segment scan driver: microcoded sequencer, radix divider and serial frame shifter.
// Refresh tick: once accepted, 16 serial bits leave one per cycle (a stalled output holds the
// shifter), then the scan position advances. Load: per digit, set-up, 16 steps of the
// one-bit-per-cycle restoring divider and a store; a load gives no serial bits.
// Reset (arst_n low, asynchronous): registers to defaults, digit 0 shows zero, scan at 0.
module seven_segment_scan_driver #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [15:0] number
	input  logic                            s_tuser,   // [0] func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [0] ser_level, [7:1] zero
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sssd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sssd_pkg::*;

	localparam int unsigned PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int unsigned CW = (PW > 2) ? PW : 2;
	localparam logic [PW-1:0] LAST_DIG = PW'(DIGIT_COUNT - 1);

	// configuration
	logic [RADIX_W-1:0] radix_q;
	logic               blank_q;
	logic               point_en_q;
	logic [1:0]         point_pos_q;
	logic               digit_on_q;
	logic               seg_on_q;

	// sequencer and datapath
	upc_t               pc_q;
	upc_t               pc_d;
	uword_t             uw;
	logic [BITCNT_W-1:0] cnt_q;
	logic [PW-1:0]      dig_q;
	logic [PW-1:0]      scan_q;
	logic [NUM_W-1:0]   val_q;
	logic [REM_W-1:0]   rem_q;
	logic [FRAME_W-1:0] frame_q;
	logic [BYTE_W-1:0]  masks_q [DIGIT_COUNT];
	logic               m_tvalid_q;
	logic               ser_q;
	logic               last_q;

	logic               in_acc;
	logic               slot_free;
	logic               emit;
	logic               stall;
	logic               taken;
	logic [RADIX_W-1:0] base;
	logic [RADIX_W-1:0] trial;
	logic [RADIX_W-1:0] diff;
	logic               ge;
	logic [1:0]         thresh;
	logic               blank_dig;
	logic               point_hit;
	logic [BYTE_W-1:0]  new_mask;
	logic [PW-1:0]      sp;
	logic [BYTE_W-1:0]  sel_byte;
	logic [BYTE_W-1:0]  seg_byte;

	assign uw        = ucode_rom(pc_q);
	assign s_tready  = (uw.op == OP_WAIT);
	assign in_acc    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign emit      = (uw.op == OP_EMIT) && slot_free;
	assign stall     = ((uw.op == OP_WAIT) && !in_acc) || ((uw.op == OP_EMIT) && !slot_free);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {7'b0, ser_q};
	assign m_tlast   = last_q;

	always_comb begin
		unique case (uw.cnd)
			CND_NEXT:     taken = 1'b0;
			CND_ALWAYS:   taken = 1'b1;
			CND_CNT_NZ:   taken = (cnt_q != '0);
			CND_DIG_MORE: taken = (dig_q != LAST_DIG);
			CND_TICK:     taken = s_tuser;
			default:      taken = 1'b0;
		endcase
		if (stall) begin
			pc_d = pc_q;
		end else if (taken) begin
			pc_d = uw.target;
		end else begin
			pc_d = upc_t'(pc_q + 3'd1);
		end
	end

	// restoring division, one quotient bit per step; remainder stays below the base
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
		trial = {rem_q, val_q[NUM_W-1]};
		ge    = (trial >= base);
		diff  = trial - base;
	end

	always_comb begin
		thresh    = point_en_q ? point_pos_q : 2'd0;
		blank_dig = blank_q && (CW'(dig_q) > CW'(thresh)) && (val_q == '0) && (rem_q == '0);
		point_hit = point_en_q && (CW'(dig_q) == CW'(point_pos_q));
		new_mask  = blank_dig ? '0 : (hex_font(rem_q) | (point_hit ? POINT_MASK : '0));
	end

	always_comb begin
		sp       = (32'(scan_q) >= DIGIT_COUNT) ? '0 : scan_q;
		sel_byte = (BYTE_W'(1) << sp) ~^ {BYTE_W{digit_on_q}};
		seg_byte = masks_q[sp] ~^ {BYTE_W{seg_on_q}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			blank_q     <= 1'b1;
			point_en_q  <= 1'b0;
			point_pos_q <= 2'd0;
			digit_on_q  <= 1'b0;
			seg_on_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RADIX:     radix_q     <= cfg_data[RADIX_W-1:0];
				CFG_BLANK:     blank_q     <= cfg_data[0];
				CFG_POINT_EN:  point_en_q  <= cfg_data[0];
				CFG_POINT_POS: point_pos_q <= cfg_data[1:0];
				CFG_DIGIT_ON:  digit_on_q  <= cfg_data[0];
				CFG_SEG_ON:    seg_on_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_WAIT;
			cnt_q      <= '0;
			dig_q      <= '0;
			scan_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				masks_q[i] <= (i == 0) ? hex_font(4'h0) : '0;
			end
		end else begin
			pc_q <= pc_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (uw.op)
				OP_WAIT: begin
					if (in_acc) begin
						dig_q <= '0;
						cnt_q <= FRAME_LAST_BIT;
					end
				end
				OP_DIV_INIT: cnt_q <= DIV_LAST_BIT;
				OP_DIV_STEP: cnt_q <= cnt_q - 1'b1;
				OP_STORE: begin
					masks_q[dig_q] <= new_mask;
					dig_q          <= PW'(dig_q + 1'b1);
				end
				OP_EMIT: begin
					if (slot_free) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				OP_SCAN_ADV: scan_q <= (sp == LAST_DIG) ? '0 : PW'(sp + 1'b1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_WAIT: begin
				if (in_acc) begin
					val_q   <= s_tdata;
					frame_q <= {sel_byte, seg_byte};
				end
			end
			OP_DIV_INIT: rem_q <= '0;
			OP_DIV_STEP: begin
				rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
				val_q <= {val_q[NUM_W-2:0], ge};
			end
			OP_EMIT: begin
				// shift the frame out most significant bit first
				if (slot_free) begin
					ser_q   <= frame_q[FRAME_W-1];
					last_q  <= (cnt_q == '0);
					frame_q <= {frame_q[FRAME_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: sim/tb.sv
// Self-checking testbench for the seven-segment scan driver: loads, refresh ticks, register settings.
`timescale 1ns / 1ps

module tb;
	import sssd_pkg::*;

	localparam int DIGITS          = 4;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 45;
	localparam int SETTLE_CYCLES   = 100;
	localparam int HOLD_AT_ITEM    = 60;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 3000;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// No register behind this index: a write must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	// Font masks for digits 0..F, digit 0 in the lowest byte.
	localparam logic [16*BYTE_W-1:0] GLYPH_TABLE = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};
	// Radix per phase, phase 0 in the lowest bits; includes values that saturate.
	localparam logic [PHASES*RADIX_W-1:0] RADIX_PLAN = {
		5'd10, 5'd7, 5'd17, 5'd1, 5'd31, 5'd0, 5'd16, 5'd2
	};
	localparam logic [4*NUM_W-1:0] DIRECTED_NUMBERS = {16'd7, 16'd1234, 16'hFFFF, 16'd0};

	typedef struct packed {
		logic             func;
		logic [NUM_W-1:0] number;
	} display_item_t;

	typedef struct packed {
		logic ser_level;
		logic last;
	} serial_bit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;    // [15:0] number
	logic s_tuser = 1'b0;         // [0] func
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;          // [0] ser_level, [7:1] zero
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state and its copy of the registers
	logic [RADIX_W-1:0] radix_reg;
	logic blank_zeros;
	logic point_on;
	logic [1:0] point_digit;
	logic common_level;
	logic segment_level;
	logic [BYTE_W-1:0] glyphs [DIGITS];
	int scan_digit;

	display_item_t pending_items[$];
	serial_bit_t serial_bits[$];
	display_item_t next_item;
	serial_bit_t wanted;

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned bits_seen = 0;
	int unsigned failures = 0;
	int unsigned sender_gap = 0;
	int unsigned receiver_wait = 0;
	int unsigned wait_draw;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic hold_output = 1'b0;
	logic hold_done = 1'b0;
	logic sender_calm = 1'b0;
	logic receiver_calm = 1'b0;

	seven_segment_scan_driver #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned draw_wait(input logic calm);
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 16);
	endfunction

	function automatic logic [NUM_W-1:0] draw_number();
		logic [NUM_W-1:0] n;
		n = NUM_W'($urandom);
		case ($urandom_range(0, 3))
			0: return NUM_W'($urandom_range(0, 15));
			1: return NUM_W'($urandom_range(0, 400));
			2: return n >> $urandom_range(0, 15);
			default: return n;
		endcase
	endfunction

	// Split a number into digits and store their masks, as a load does.
	function automatic void render_number(input logic [NUM_W-1:0] value);
		int unsigned rest;
		int unsigned base;
		int unsigned threshold;
		int unsigned digit;
		logic [BYTE_W-1:0] glyph;
		rest = 32'(value);
		base = 32'(radix_reg);
		if (base < 32'(RADIX_MIN))
			base = 32'(RADIX_MIN);
		if (base > 32'(RADIX_MAX))
			base = 32'(RADIX_MAX);
		threshold = point_on ? 32'(point_digit) : 32'd0;
		for (int i = 0; i < DIGITS; i++) begin
			digit = rest % base;
			rest = rest / base;
			if (blank_zeros && i > threshold && rest == 0 && digit == 0) begin
				glyphs[i] = '0;
			end else begin
				glyph = GLYPH_TABLE[digit*BYTE_W +: BYTE_W];
				if (point_on && i == point_digit)
					glyph = glyph | POINT_MASK;
				glyphs[i] = glyph;
			end
		end
	endfunction

	// Queue the sixteen serial bits of one refresh tick, then advance the scan.
	function automatic void queue_frame();
		serial_bit_t b;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			b.ser_level = (i == scan_digit) ? common_level : ~common_level;
			b.last = 1'b0;
			serial_bits.push_back(b);
		end
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			b.ser_level = glyphs[scan_digit][i] ? segment_level : ~segment_level;
			b.last = (i == 0);
			serial_bits.push_back(b);
		end
		scan_digit = (scan_digit + 1) % DIGITS;
	endfunction

	function automatic void queue_item(input logic func, input logic [NUM_W-1:0] number);
		display_item_t item;
		item.func = func;
		item.number = number;
		pending_items.push_back(item);
		items_queued++;
	endfunction

	task automatic report_mismatch(input string msg);
		failures++;
		$display("mismatch: %s", msg);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RADIX:     radix_reg = value;
			CFG_BLANK:     blank_zeros = value[0];
			CFG_POINT_EN:  point_on = value[0];
			CFG_POINT_POS: point_digit = value[1:0];
			CFG_DIGIT_ON:  common_level = value[0];
			CFG_SEG_ON:    segment_level = value[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every item to be taken and every bit to arrive, then let a load finish.
	task automatic wait_drained();
		do @(posedge clk); while (items_taken != items_queued || serial_bits.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			sender_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_LOAD)
					render_number(s_tdata);
				else
					queue_frame();
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (sender_gap != 0) begin
					sender_gap <= sender_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_item.func;
					s_tdata <= next_item.number;
					sender_gap <= draw_wait(sender_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Serial bit monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			receiver_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			bits_seen++;
			if (serial_bits.size() == 0) begin
				report_mismatch($sformatf("serial bit %0d arrived with none expected", bits_seen));
			end else begin
				wanted = serial_bits.pop_front();
				if (m_tdata[0] !== wanted.ser_level)
					report_mismatch($sformatf("serial bit %0d ser_level %b, expected %b",
						bits_seen, m_tdata[0], wanted.ser_level));
				if (m_tlast !== wanted.last)
					report_mismatch($sformatf("serial bit %0d last %b, expected %b",
						bits_seen, m_tlast, wanted.last));
			end
			wait_draw = draw_wait(receiver_calm);
			receiver_wait <= (wait_draw == 0) ? 0 : wait_draw - 1;
			m_tready <= (wait_draw == 0) && !hold_output;
		end else if (receiver_wait != 0) begin
			receiver_wait <= receiver_wait - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_output;
		end
	end

	// Hold the output off once for a long stretch so the input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_output <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			hold_output <= (hold_left != 1);
		end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_output <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int unsigned issued;
		radix_reg = RADIX_RESET;
		blank_zeros = 1'b1;
		point_on = 1'b0;
		point_digit = 2'd0;
		common_level = 1'b0;
		segment_level = 1'b1;
		for (int i = 0; i < DIGITS; i++)
			glyphs[i] = '0;
		glyphs[0] = 8'h3F;
		scan_digit = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset contents on every digit, then zero, full scale, a plain value, a blanked one
		repeat (DIGITS) queue_item(FUNC_TICK, NUM_W'($urandom));
		for (int k = 0; k < 4; k++) begin
			queue_item(FUNC_LOAD, DIRECTED_NUMBERS[k*NUM_W +: NUM_W]);
			repeat (DIGITS) queue_item(FUNC_TICK, NUM_W'($urandom));
		end
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_register(CFG_RADIX, RADIX_PLAN[p*RADIX_W +: RADIX_W]);
			write_register(CFG_BLANK, {4'd0, ~p[0]});
			write_register(CFG_POINT_EN, {4'd0, p[1]});
			write_register(CFG_POINT_POS,
				(p < 4) ? CFG_DATA_W'(p[1:0]) : CFG_DATA_W'($urandom_range(0, 3)));
			write_register(CFG_DIGIT_ON, {4'd0, p[2]});
			write_register(CFG_SEG_ON, {4'd0, p[0] ^ p[2] ^ 1'b1});
			if (p == 0)
				write_register(CFG_SPARE, 5'h1F);
			sender_calm = (p % 4 == 1);
			receiver_calm = (p % 4 == 2);

			issued = 0;
			while (issued < PHASE_ITEMS) begin
				if ($urandom_range(0, 2) != 0) begin
					// Load followed by one full scan of the digits
					queue_item(FUNC_LOAD, draw_number());
					repeat (DIGITS) queue_item(FUNC_TICK, NUM_W'($urandom));
					issued += DIGITS + 1;
				end else begin
					if ($urandom_range(0, 3) == 0)
						queue_item(FUNC_LOAD, draw_number());
					else
						queue_item(FUNC_TICK, NUM_W'($urandom));
					issued++;
				end
			end
			wait_drained();
		end

		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
